### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the statistics core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/twstat_pkg.sv
// Package for the time window statistics core: widths, ring entry and request
// types, sequencer states and the ring / squaring helpers. No dependencies.
`default_nettype none

package twstat_pkg;

    localparam int DEPTH       = 256;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int COUNT_W     = PTR_W + 1;
    localparam int SAMPLE_W    = 24;
    localparam int SDEV_W      = SAMPLE_W - 1;
    localparam int STAMP_W     = 48;
    localparam int WINDOW_W    = 32;
    localparam int SUM_W       = 32;
    localparam int SQ_W        = 56;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int REM_W       = 32;
    localparam int DIV_STEPS   = SQ_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;
    localparam logic [SDEV_W-1:0]   SDEV_MAX     = '1;

    typedef struct packed {
        logic [STAMP_W-1:0]         stamp;
        logic signed [SAMPLE_W-1:0] value;
    } entry_t;

    // request from the sequencer to the shared divide / square-root unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } dsu_req_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NEW_RD, ST_NEW_CHK, ST_FULL_RD, ST_FULL_CHK, ST_PLACE,
        ST_SUB_MUL, ST_SUB_UPD, ST_ADD_MUL, ST_ADD_UPD, ST_EV_RD, ST_EV_CHK,
        ST_STATS, ST_DIV_SUM, ST_DIV_SQ, ST_MSQ_MUL, ST_VAR, ST_SQRT,
        ST_SCAN, ST_OUT
    } state_t;

    // where to go after removing a value from the running sums
    typedef enum logic [1:0] {
        CTX_REPLACE, CTX_PLACE, CTX_EVICT
    } ctx_t;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PROD_W-1:0] sq_mag(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] mag;
        mag = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : v;
        return mag * mag;
    endfunction

endpackage

`default_nettype wire

### rtl/core/twstat_ring.sv
// Sample ring memory: stamp and value per entry, one write and one
// registered read port. Depends on twstat_pkg.
`default_nettype none

module twstat_ring (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [twstat_pkg::PTR_W-1:0] wr_addr,
    input  wire twstat_pkg::entry_t        wr_data,
    input  wire logic [twstat_pkg::PTR_W-1:0] rd_addr,
    output twstat_pkg::entry_t             rd_data
);

    twstat_pkg::entry_t mem [twstat_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/twstat_dsu.sv
// Shared serial unit: restoring division by the count (one bit a cycle)
// and digit-by-digit square root (two bits a cycle). Depends on twstat_pkg.
`default_nettype none

module twstat_dsu (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire twstat_pkg::dsu_req_t          req,
    input  wire logic [twstat_pkg::SQ_W-1:0]    operand,
    input  wire logic [twstat_pkg::COUNT_W-1:0] divisor,
    output logic                               done,
    output logic [twstat_pkg::SQ_W-1:0]        result
);

    logic [twstat_pkg::SQ_W-1:0]    opnd_reg, opnd_next;
    logic [twstat_pkg::SQ_W-1:0]    res_reg, res_next;
    logic [twstat_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [twstat_pkg::COUNT_W-1:0] div_reg, div_next;
    logic                           sqrt_reg, sqrt_next;
    logic [twstat_pkg::STEP_W-1:0]  count_reg, count_next;
    logic                           done_reg, done_next;
    logic [twstat_pkg::REM_W-1:0]   sh;
    logic [twstat_pkg::REM_W-1:0]   trial;

    always_comb begin
        opnd_next  = opnd_reg;
        res_next   = res_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        sqrt_next  = sqrt_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        sh         = '0;
        trial      = '0;
        if (req.start) begin
            opnd_next  = operand;
            div_next   = divisor;
            sqrt_next  = req.is_sqrt;
            rem_next   = '0;
            res_next   = '0;
            count_next = req.is_sqrt ? twstat_pkg::STEP_W'(twstat_pkg::SQRT_STEPS)
                                     : twstat_pkg::STEP_W'(twstat_pkg::DIV_STEPS);
        end else if (count_reg != '0) begin
            if (sqrt_reg) begin
                sh    = {rem_reg[twstat_pkg::REM_W-3:0],
                         opnd_reg[twstat_pkg::SQ_W-1 -: 2]};
                trial = {2'b00, res_reg[twstat_pkg::ROOT_W-1:0], 2'b01};
                opnd_next = {opnd_reg[twstat_pkg::SQ_W-3:0], 2'b00};
            end else begin
                sh    = {rem_reg[twstat_pkg::REM_W-2:0], opnd_reg[twstat_pkg::SQ_W-1]};
                trial = twstat_pkg::REM_W'(div_reg);
                opnd_next = {opnd_reg[twstat_pkg::SQ_W-2:0], 1'b0};
            end
            if (sh >= trial) begin
                rem_next = sh - trial;
                res_next = {res_reg[twstat_pkg::SQ_W-2:0], 1'b1};
            end else begin
                rem_next = sh;
                res_next = {res_reg[twstat_pkg::SQ_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == twstat_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd_next;
        res_reg  <= res_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        sqrt_reg <= sqrt_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### rtl/core/time_window_statistics_core.sv
// Top level of the time window statistics core: sequencer, running sums,
// squaring multiplier and min/max scan. Depends on twstat_pkg, twstat_ring, twstat_dsu.
//
//  channel   | ports                   | item
//  ----------+-------------------------+------------------------------------------
//  input     | s_tvalid/s_tready/...   | opcode (tuser), sample, timestamp_ms
//  result    | m_tvalid/m_tready/...   | mean, stddev, count, min, max, flags
//  config    | cfg_wr_en/cfg_wr_data   | window_ms, written any cycle
//
// Sequence: a clear item goes straight to the result. An append checks the newest
//   entry, replaces or evicts as needed, then runs two 56-step divides and a
//   28-step root on the serial divide/root unit and scans the held entries
//   through the single ring read port for min and max.
// Reset: aresetn synchronous; pointers, count and sums clear at once, the ring
//   itself is not cleared (only written entries are ever read).
// Stalls: s_tready is high only while idle; a finished result sits in the output
//   register while the next item is taken, and the sequencer waits only
//   when a second result is ready before the first was taken.
`default_nettype none

module time_window_statistics_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // [23:0] sample, [71:24] timestamp_ms
    input  wire logic [0:0]   s_tuser,   // [0] opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // [23:0] mean, [46:24] stddev,
                                         // [55:47] sample_count, [79:56] minimum,
                                         // [103:80] maximum
    output logic [1:0]        m_tuser,   // [0] empty_res, [1] dropped
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data
);

    localparam int SW = twstat_pkg::SAMPLE_W;
    localparam int PW = twstat_pkg::PTR_W;
    localparam int CW = twstat_pkg::COUNT_W;

    twstat_pkg::state_t state_reg, state_next;
    twstat_pkg::ctx_t   ctx_reg, ctx_next;

    // control state
    logic [PW-1:0]                    oldest_reg, oldest_next;
    logic [PW-1:0]                    newest_reg, newest_next;
    logic [CW-1:0]                    held_reg, held_next;
    logic signed [twstat_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [twstat_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic [twstat_pkg::WINDOW_W-1:0]  window_reg, window_next;
    logic                             m_valid_reg, m_valid_next;
    logic [CW-1:0]                    scan_left_reg, scan_left_next;
    logic                             pend_reg, pend_next;

    // payload
    logic signed [SW-1:0]             sample_reg, sample_next;
    logic [twstat_pkg::STAMP_W-1:0]   t_reg, t_next;
    logic [twstat_pkg::STAMP_W-1:0]   limit_reg, limit_next;
    logic signed [SW-1:0]             val_reg, val_next;
    logic                             dropped_reg, dropped_next;
    logic signed [SW-1:0]             mean_reg, mean_next;
    logic [twstat_pkg::SQ_W-1:0]      msq_reg, msq_next;
    logic [twstat_pkg::SDEV_W-1:0]    sdev_reg, sdev_next;
    logic signed [SW-1:0]             min_reg, min_next;
    logic signed [SW-1:0]             max_reg, max_next;
    logic                             first_reg, first_next;
    logic [PW-1:0]                    scan_ptr_reg, scan_ptr_next;
    logic [twstat_pkg::PROD_W-1:0]    prod_reg;
    logic [103:0]                     out_data_reg, out_data_next;
    logic [1:0]                       out_user_reg, out_user_next;

    // ring and shared unit wiring
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr, ram_raddr;
    twstat_pkg::entry_t    ram_wdata, ram_rdata;
    twstat_pkg::dsu_req_t  dsu_req;
    logic [twstat_pkg::SQ_W-1:0] dsu_operand, dsu_result;
    logic                  dsu_done;
    logic signed [SW-1:0]  mul_in;
    logic [PW-1:0]         place_addr;
    logic [twstat_pkg::SUM_W-1:0] sum_mag;

    twstat_ring u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    twstat_dsu u_dsu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dsu_req),
        .operand (dsu_operand),
        .divisor (held_reg),
        .done    (dsu_done),
        .result  (dsu_result)
    );

    assign sum_mag    = sum_reg[twstat_pkg::SUM_W-1] ? twstat_pkg::SUM_W'(-sum_reg)
                                                     : twstat_pkg::SUM_W'(sum_reg);
    assign place_addr = (held_reg == '0) ? oldest_reg : twstat_pkg::ring_next(newest_reg);

    always_comb begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        window_next    = cfg_wr_en ? cfg_wr_data : window_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        scan_left_next = scan_left_reg;
        pend_next      = pend_reg;
        sample_next    = sample_reg;
        t_next         = t_reg;
        limit_next     = limit_reg;
        val_next       = val_reg;
        dropped_next   = dropped_reg;
        mean_next      = mean_reg;
        msq_next       = msq_reg;
        sdev_next      = sdev_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        first_next     = first_reg;
        scan_ptr_next  = scan_ptr_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = newest_reg;
        ram_wdata      = '{stamp: t_reg, value: sample_reg};
        ram_raddr      = oldest_reg;
        dsu_req        = '0;
        dsu_operand    = '0;
        mul_in         = val_reg;

        unique case (state_reg)
            twstat_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next  = s_tdata[SW-1:0];
                    t_next       = s_tdata[71:24];
                    dropped_next = 1'b0;
                    if (s_tuser[0] == twstat_pkg::OP_CLEAR) begin
                        oldest_next = '0;
                        newest_next = '0;
                        held_next   = '0;
                        sum_next    = '0;
                        sq_next     = '0;
                        state_next  = twstat_pkg::ST_STATS;
                    end else begin
                        state_next  = twstat_pkg::ST_NEW_RD;
                    end
                end
            end
            twstat_pkg::ST_NEW_RD: begin
                ram_raddr  = newest_reg;
                state_next = twstat_pkg::ST_NEW_CHK;
            end
            twstat_pkg::ST_NEW_CHK: begin
                if (held_reg != '0 && ram_rdata.stamp == t_reg) begin
                    // same stamp as newest: overwrite its value
                    val_next   = ram_rdata.value;
                    ram_we     = 1'b1;
                    ctx_next   = twstat_pkg::CTX_REPLACE;
                    state_next = twstat_pkg::ST_SUB_MUL;
                end else if (held_reg == CW'(twstat_pkg::DEPTH)) begin
                    state_next = twstat_pkg::ST_FULL_RD;
                end else begin
                    state_next = twstat_pkg::ST_PLACE;
                end
            end
            twstat_pkg::ST_FULL_RD: begin
                state_next = twstat_pkg::ST_FULL_CHK;
            end
            twstat_pkg::ST_FULL_CHK: begin
                val_next     = ram_rdata.value;
                oldest_next  = twstat_pkg::ring_next(oldest_reg);
                held_next    = held_reg - 1'b1;
                dropped_next = 1'b1;
                ctx_next     = twstat_pkg::CTX_PLACE;
                state_next   = twstat_pkg::ST_SUB_MUL;
            end
            twstat_pkg::ST_PLACE: begin
                ram_we      = 1'b1;
                ram_waddr   = place_addr;
                newest_next = place_addr;
                held_next   = held_reg + 1'b1;
                state_next  = twstat_pkg::ST_ADD_MUL;
            end
            twstat_pkg::ST_SUB_MUL: begin
                state_next = twstat_pkg::ST_SUB_UPD;
            end
            twstat_pkg::ST_SUB_UPD: begin
                sum_next = sum_reg - twstat_pkg::SUM_W'(val_reg);
                sq_next  = sq_reg - twstat_pkg::SQ_W'(prod_reg);
                unique case (ctx_reg)
                    twstat_pkg::CTX_REPLACE: state_next = twstat_pkg::ST_ADD_MUL;
                    twstat_pkg::CTX_PLACE:   state_next = twstat_pkg::ST_PLACE;
                    twstat_pkg::CTX_EVICT:   state_next = twstat_pkg::ST_EV_RD;
                    default:                 state_next = twstat_pkg::ST_EV_RD;
                endcase
            end
            twstat_pkg::ST_ADD_MUL: begin
                mul_in     = sample_reg;
                state_next = twstat_pkg::ST_ADD_UPD;
            end
            twstat_pkg::ST_ADD_UPD: begin
                sum_next   = sum_reg + twstat_pkg::SUM_W'(sample_reg);
                sq_next    = sq_reg + twstat_pkg::SQ_W'(prod_reg);
                limit_next = t_reg - twstat_pkg::STAMP_W'(window_reg);
                // before the first full window nothing is stale
                state_next = (t_reg >= twstat_pkg::STAMP_W'(window_reg))
                           ? twstat_pkg::ST_EV_RD : twstat_pkg::ST_STATS;
            end
            twstat_pkg::ST_EV_RD: begin
                state_next = (held_reg > CW'(1)) ? twstat_pkg::ST_EV_CHK
                                                 : twstat_pkg::ST_STATS;
            end
            twstat_pkg::ST_EV_CHK: begin
                if (ram_rdata.stamp < limit_reg) begin
                    val_next    = ram_rdata.value;
                    oldest_next = twstat_pkg::ring_next(oldest_reg);
                    held_next   = held_reg - 1'b1;
                    ctx_next    = twstat_pkg::CTX_EVICT;
                    state_next  = twstat_pkg::ST_SUB_MUL;
                end else begin
                    state_next  = twstat_pkg::ST_STATS;
                end
            end
            twstat_pkg::ST_STATS: begin
                if (held_reg == '0) begin
                    mean_next  = '0;
                    sdev_next  = '0;
                    min_next   = '0;
                    max_next   = '0;
                    state_next = twstat_pkg::ST_OUT;
                end else begin
                    dsu_req.start = 1'b1;
                    dsu_operand   = twstat_pkg::SQ_W'(sum_mag);
                    state_next    = twstat_pkg::ST_DIV_SUM;
                end
            end
            twstat_pkg::ST_DIV_SUM: begin
                if (dsu_done) begin
                    // truncate toward zero: divide the magnitude, restore sign
                    mean_next = sum_reg[twstat_pkg::SUM_W-1] ? SW'(-dsu_result[SW-1:0])
                                                             : dsu_result[SW-1:0];
                    dsu_req.start = 1'b1;
                    dsu_operand   = sq_reg;
                    state_next    = twstat_pkg::ST_DIV_SQ;
                end
            end
            twstat_pkg::ST_DIV_SQ: begin
                if (dsu_done) begin
                    msq_next   = dsu_result;
                    state_next = twstat_pkg::ST_MSQ_MUL;
                end
            end
            twstat_pkg::ST_MSQ_MUL: begin
                mul_in     = mean_reg;
                state_next = twstat_pkg::ST_VAR;
            end
            twstat_pkg::ST_VAR: begin
                dsu_req.start   = 1'b1;
                dsu_req.is_sqrt = 1'b1;
                dsu_operand     = (msq_reg > twstat_pkg::SQ_W'(prod_reg))
                                ? msq_reg - twstat_pkg::SQ_W'(prod_reg) : '0;
                state_next      = twstat_pkg::ST_SQRT;
            end
            twstat_pkg::ST_SQRT: begin
                if (dsu_done) begin
                    sdev_next = (dsu_result[twstat_pkg::ROOT_W-1:0]
                                 > twstat_pkg::ROOT_W'(twstat_pkg::SDEV_MAX))
                              ? twstat_pkg::SDEV_MAX : dsu_result[twstat_pkg::SDEV_W-1:0];
                    scan_ptr_next  = oldest_reg;
                    scan_left_next = held_reg;
                    pend_next      = 1'b0;
                    first_next     = 1'b1;
                    state_next     = twstat_pkg::ST_SCAN;
                end
            end
            twstat_pkg::ST_SCAN: begin
                // one read issued per cycle, compare on the registered read data in the cycle after
                ram_raddr = scan_ptr_reg;
                if (scan_left_reg != '0) begin
                    scan_ptr_next  = twstat_pkg::ring_next(scan_ptr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                    pend_next      = 1'b1;
                end else begin
                    pend_next      = 1'b0;
                end
                if (pend_reg) begin
                    first_next = 1'b0;
                    if (first_reg || ram_rdata.value < min_reg) begin
                        min_next = ram_rdata.value;
                    end
                    if (first_reg || ram_rdata.value > max_reg) begin
                        max_next = ram_rdata.value;
                    end
                end
                if (scan_left_reg == '0 && !pend_reg) begin
                    state_next = twstat_pkg::ST_OUT;
                end
            end
            twstat_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_data_next = {max_reg, min_reg, held_reg, sdev_reg, mean_reg};
                    out_user_next = {dropped_reg, held_reg == '0};
                    m_valid_next  = 1'b1;
                    state_next    = twstat_pkg::ST_IDLE;
                end
            end
            default: state_next = twstat_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= twstat_pkg::ST_IDLE;
            ctx_reg       <= twstat_pkg::CTX_PLACE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            window_reg    <= twstat_pkg::WINDOW_RESET;
            m_valid_reg   <= 1'b0;
            scan_left_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            window_reg    <= window_next;
            m_valid_reg   <= m_valid_next;
            scan_left_reg <= scan_left_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        t_reg        <= t_next;
        limit_reg    <= limit_next;
        val_reg      <= val_next;
        dropped_reg  <= dropped_next;
        mean_reg     <= mean_next;
        msq_reg      <= msq_next;
        sdev_reg     <= sdev_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        first_reg    <= first_next;
        scan_ptr_reg <= scan_ptr_next;
        prod_reg     <= twstat_pkg::sq_mag(mul_in);
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_tready = (state_reg == twstat_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

### rtl/core/twstat_checker.sv
// Port-level checker for the statistics core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module twstat_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after accept")
    `ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[55:47] == 9'd0 && m_tdata[23:0] == 24'd0 && m_tdata[103:56] == 48'd0, "empty result not zero")
    `ASSERT_IMPLY(a_min_le_max, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[55:47] != 9'd0 && $signed(m_tdata[79:56]) <= $signed(m_tdata[103:80]), "min above max")
    `ASSERT_IMPLY(a_count_range, aclk, aresetn, m_tvalid, m_tdata[55:47] <= 9'd256, "count above depth")

endmodule

bind time_window_statistics_core twstat_checker u_twstat_checker (.*);

`default_nettype wire
